>>> hw/rtl/hsd_pkg.sv
// Shared types and constants for the Hamming single-error-correcting decoder.
// No dependencies; imported by hsd_decode, hamming_sec_decoder_core and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package hsd_pkg;

  // Fixed field widths of the codeword, data and syndrome ports
  localparam int CW_W   = 63;
  localparam int DATA_W = 57;
  localparam int SYN_W  = 6;

  // Parity-bit count register
  localparam int                CFG_W        = 3;
  localparam logic [CFG_W-1:0]  PARITY_RESET = 3'd6;

  // One decoded result as it leaves the decode logic
  typedef struct packed {
    logic [DATA_W-1:0] data_bits;
    logic [SYN_W-1:0]  syndrome;
  } hsd_result_t;

endpackage : hsd_pkg

`default_nettype wire

>>> hw/rtl/hsd_decode.sv
// Combinational Hamming decode: position mapping, syndrome, correction, data compaction.
// Depends on hsd_pkg for widths and the hsd_result_t struct.
`timescale 1ns / 1ps
`default_nettype none

module hsd_decode
  import hsd_pkg::*;
#(
  parameter int MAX_PARITY_BITS = 6
) (
  input  wire logic [CW_W-1:0]  codeword,
  input  wire logic [CFG_W-1:0] parity_bits,
  output hsd_result_t           result
);

  localparam int MAX_N = (2 ** MAX_PARITY_BITS) - 1;
  localparam int MAX_M = MAX_N - MAX_PARITY_BITS;

  // Position-ordered codeword for each possible parity count; position p at bit n - p
  logic [MAX_N:1]   cand  [MAX_PARITY_BITS];
  logic [MAX_N:1]   pos;
  logic [MAX_N:1]   corr;
  logic [MAX_PARITY_BITS-1:0] syn;
  logic [MAX_M-1:0] lin;
  logic [MAX_M-1:0] dcand [MAX_PARITY_BITS];
  logic [MAX_M-1:0] data;

  for (genvar rr = 1; rr <= MAX_PARITY_BITS; rr++) begin : g_map
    for (genvar p = 1; p <= MAX_N; p++) begin : g_pos
      if (p <= (2 ** rr) - 1) begin : g_in
        assign cand[rr-1][p] = codeword[(2 ** rr) - 1 - p];
      end else begin : g_out
        assign cand[rr-1][p] = 1'b0;
      end
    end
  end

  // Pick the mapping for the active parity count
  always_comb begin
    pos = '0;
    for (int k = 0; k < MAX_PARITY_BITS; k++) begin
      if (parity_bits == CFG_W'(k + 1)) begin
        pos = cand[k];
      end
    end
  end

  // Syndrome bit k: parity over every position that contains power 2^k
  always_comb begin
    syn = '0;
    for (int k = 0; k < MAX_PARITY_BITS; k++) begin
      for (int p = 1; p <= MAX_N; p++) begin
        if (((p >> k) & 1) == 1) begin
          syn[k] = syn[k] ^ pos[p];
        end
      end
    end
  end

  // Flip the named position; a zero syndrome names none
  always_comb begin
    for (int p = 1; p <= MAX_N; p++) begin
      corr[p] = pos[p] ^ (syn == MAX_PARITY_BITS'(p));
    end
  end

  // Drop power-of-two positions, keep data positions in ascending order
  for (genvar p = 3; p <= MAX_N; p++) begin : g_lin
    if ((p & (p - 1)) != 0) begin : g_data
      assign lin[p - 1 - $clog2(p + 1)] = corr[p];
    end
  end

  // Right-align with the lowest position as the most significant bit
  for (genvar rr = 1; rr <= MAX_PARITY_BITS; rr++) begin : g_align
    localparam int MM = (2 ** rr) - 1 - rr;
    for (genvar i = 0; i < MAX_M; i++) begin : g_bit
      if (i < MM) begin : g_used
        assign dcand[rr-1][i] = lin[MM - 1 - i];
      end else begin : g_zero
        assign dcand[rr-1][i] = 1'b0;
      end
    end
  end

  always_comb begin
    data = '0;
    for (int k = 0; k < MAX_PARITY_BITS; k++) begin
      if (parity_bits == CFG_W'(k + 1)) begin
        data = dcand[k];
      end
    end
  end

  assign result.data_bits = DATA_W'(data);
  assign result.syndrome  = SYN_W'(syn);

endmodule : hsd_decode

`default_nettype wire

>>> hw/rtl/hamming_sec_decoder_core.sv
// Top level of the Hamming single-error-correcting decoder: config register, input and
// result registers around the decode logic. Depends on hsd_pkg and hsd_decode.
//
//   Channel   Handshake          Payload                   Direction
//   -------   ----------------   -----------------------   ---------
//   config    cfg_we             cfg_data[2:0]             in
//   input     start, busy        codeword[62:0]            in
//   result    done (strobe)      data_bits[56:0],          out
//                                syndrome[5:0]
//
// One codeword is taken every cycle; busy stays low.
// Each result passes through the input register, then through the decode XOR trees
// into the result register.
// The parity-bit count is sampled with each codeword, so a later write does not alter it.
// rst is synchronous and clears the pipeline valids and sets the parity count to six.
// The receiver cannot stall; done is a single-cycle strobe per result.
`timescale 1ns / 1ps
`default_nettype none

module hamming_sec_decoder_core
  import hsd_pkg::*;
#(
  parameter int MAX_PARITY_BITS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [CW_W-1:0]   codeword,
  output      logic              done,
  output      logic [DATA_W-1:0] data_bits,
  output      logic [SYN_W-1:0]  syndrome
);

  logic [CFG_W-1:0] parity_bits;
  logic [CFG_W-1:0] r_eff;
  logic             in_valid;
  logic [CW_W-1:0]  in_cw;
  logic [CFG_W-1:0] in_r;
  logic             accept;
  hsd_result_t      dec;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Hold the parity-bit count register
  always_ff @(posedge clk) begin
    if (rst) begin
      parity_bits <= PARITY_RESET;
    end else if (cfg_we) begin
      parity_bits <= cfg_data;
    end
  end

  // Saturate the count into 1..MAX_PARITY_BITS
  always_comb begin
    if (parity_bits == '0) begin
      r_eff = CFG_W'(1);
    end else if (parity_bits > CFG_W'(MAX_PARITY_BITS)) begin
      r_eff = CFG_W'(MAX_PARITY_BITS);
    end else begin
      r_eff = parity_bits;
    end
  end

  // Capture each transfer with its parity count
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cw <= codeword;
      in_r  <= r_eff;
    end
  end

  hsd_decode #(
    .MAX_PARITY_BITS (MAX_PARITY_BITS)
  ) u_decode (
    .codeword    (in_cw),
    .parity_bits (in_r),
    .result      (dec)
  );

  // Register the result and strobe it for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      data_bits <= dec.data_bits;
      syndrome  <= dec.syndrome;
    end
  end

  // Every transfer yields a strobe once it has passed the input and result registers
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("transfer did not produce a result");

  // No strobe without a matching earlier transfer
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result strobe without a matching transfer");

  // Sampled parity count is always within the saturated range
  a_r_range : assert property (@(posedge clk) disable iff (rst)
    in_valid |-> (in_r != '0) && (in_r <= CFG_W'(MAX_PARITY_BITS)))
    else $error("parity count outside saturated range");

  // Syndrome cannot exceed the largest position of the active code
  a_syn_bound : assert property (@(posedge clk) disable iff (rst)
    in_valid |-> (SYN_W + 1)'(dec.syndrome) < ((SYN_W + 1)'(1) << in_r))
    else $error("syndrome beyond codeword length");

endmodule : hamming_sec_decoder_core

`default_nettype wire

>>> tb/tb_hamming_sec_decoder_core.sv
// Self-checking testbench for hamming_sec_decoder_core: directed table, then random codewords.
// Depends on hsd_pkg and the decoder RTL; holds its own behavioural decoder.
`timescale 1ns / 1ps

module tb_hamming_sec_decoder_core;
  import hsd_pkg::*;

  localparam int MAX_R       = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED  = 24;
  localparam int N_PHASES    = 9;
  localparam int PHASE_ITEMS = 115;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_data;
  logic              start;
  logic              busy;
  logic [CW_W-1:0]   codeword;
  logic              done;
  logic [DATA_W-1:0] data_bits;
  logic [SYN_W-1:0]  syndrome;

  hamming_sec_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .codeword  (codeword),
    .done      (done),
    .data_bits (data_bits),
    .syndrome  (syndrome)
  );

  // Directed row: parity setting, codeword, and a typed-in result where it is obvious
  typedef struct packed {
    logic [CFG_W-1:0]  parity;
    logic [CW_W-1:0]   cw;
    logic              typed;
    logic [DATA_W-1:0] data;
    logic [SYN_W-1:0]  syn;
  } dir_row_t;

  dir_row_t directed_rows [0:N_DIRECTED-1] = '{
    // six parity bits (reset value)
    '{3'd6, 63'h0,                   1'b1, 57'h0,                 6'd0},
    '{3'd6, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 57'h1FF_FFFF_FFFF_FFFF, 6'd0},
    '{3'd6, 63'h4000_0000_0000_0000, 1'b1, 57'h0,                 6'd1},
    '{3'd6, 63'h1,                   1'b1, 57'h0,                 6'd63},
    '{3'd6, 63'h6000_0000_0000_0000, 1'b0, 57'h0,                 6'd0},
    '{3'd6, 63'h5555_5555_5555_5555, 1'b0, 57'h0,                 6'd0},
    '{3'd6, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 57'h0,                 6'd0},
    // single parity bit, upper bits ignored
    '{3'd1, 63'h0,                   1'b1, 57'h0,                 6'd0},
    '{3'd1, 63'h1,                   1'b1, 57'h0,                 6'd1},
    '{3'd1, 63'h7FFF_FFFF_FFFF_FFFE, 1'b1, 57'h0,                 6'd0},
    // zero behaves as one parity bit
    '{3'd0, 63'h1,                   1'b1, 57'h0,                 6'd1},
    '{3'd0, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 57'h0,                 6'd1},
    // seven saturates to six
    '{3'd7, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 57'h1FF_FFFF_FFFF_FFFF, 6'd0},
    '{3'd7, 63'h1,                   1'b1, 57'h0,                 6'd63},
    // short codes
    '{3'd2, 63'h7,                   1'b1, 57'h1,                 6'd0},
    '{3'd2, 63'h7FFF_FFFF_FFFF_FFF8, 1'b1, 57'h0,                 6'd0},
    '{3'd2, 63'h1,                   1'b1, 57'h0,                 6'd3},
    '{3'd3, 63'h7F,                  1'b1, 57'hF,                 6'd0},
    '{3'd3, 63'h10,                  1'b1, 57'h0,                 6'd3},
    '{3'd4, 63'h7FFF,                1'b1, 57'h7FF,               6'd0},
    '{3'd4, 63'h1234,                1'b0, 57'h0,                 6'd0},
    '{3'd5, 63'h7FFF_FFFF,           1'b1, 57'h3FF_FFFF,          6'd0},
    '{3'd5, 63'h1,                   1'b1, 57'h0,                 6'd31},
    '{3'd5, 63'h1234_5678_9ABC_DEF0, 1'b0, 57'h0,                 6'd0}
  };

  hsd_result_t      pending_decodes [$];
  hsd_result_t      oldest;
  logic [CFG_W-1:0] parity_setting;
  int               codewords_sent;
  int               results_checked;
  int               mismatches;
  int               cycle_count;

  // Codeword length for a raw register value, with out-of-range values clamped
  function automatic int code_length(input logic [CFG_W-1:0] r_raw);
    int r;
    r = int'(r_raw);
    if (r < 1) r = 1;
    if (r > MAX_R) r = MAX_R;
    return (1 << r) - 1;
  endfunction

  // Syndrome, single-bit correction and parity-bit removal
  function automatic hsd_result_t hamming_correct(input logic [CFG_W-1:0] r_raw,
                                                  input logic [CW_W-1:0] cw);
    int                n;
    int                syn;
    logic [63:0]       mask;
    logic [CW_W-1:0]   bits;
    logic [DATA_W-1:0] data;
    hsd_result_t       res;
    n    = code_length(r_raw);
    mask = (64'd1 << n) - 64'd1;
    bits = cw & mask[CW_W-1:0];
    syn  = 0;
    data = '0;
    for (int p = 1; p <= n; p++)
      if (bits[n-p]) syn ^= p;
    if (syn != 0) bits[n-syn] = ~bits[n-syn];
    for (int p = 1; p <= n; p++)
      if ((p & (p - 1)) != 0) data = {data[DATA_W-2:0], bits[n-p]};
    res.data_bits = data;
    res.syndrome  = syn[SYN_W-1:0];
    return res;
  endfunction

  // Mostly clean or lightly corrupted codewords, some raw noise; bits above n stay random
  function automatic logic [CW_W-1:0] random_codeword(input logic [CFG_W-1:0] r_raw);
    int              kind;
    int              n;
    int              p;
    int              q;
    logic [CW_W-1:0] cw;
    hsd_result_t     res;
    kind = $urandom_range(0, 99);
    n    = code_length(r_raw);
    cw   = CW_W'({$urandom, $urandom});
    if (kind < 90) begin
      res = hamming_correct(r_raw, cw);
      if (res.syndrome != 0) cw[n-res.syndrome] = ~cw[n-res.syndrome];
      if (kind >= 30) begin
        p = $urandom_range(1, n);
        cw[n-p] = ~cw[n-p];
        if (kind >= 75 && n > 1) begin
          q = $urandom_range(1, n);
          while (q == p) q = $urandom_range(1, n);
          cw[n-q] = ~cw[n-q];
        end
      end
    end
    return cw;
  endfunction

  // Drive one codeword and hold it until the transfer, then queue its decode
  task automatic send_codeword(input logic [CW_W-1:0] cw, input logic typed,
                               input hsd_result_t typed_res);
    hsd_result_t prediction;
    @(negedge clk);
    start    <= 1'b1;
    codeword <= cw;
    do @(posedge clk); while (busy);
    prediction      = typed ? typed_res : hamming_correct(parity_setting, cw);
    pending_decodes = {pending_decodes, prediction};
    codewords_sent++;
  endtask

  // Drop start for a burst, with junk on the codeword port
  task automatic idle_cycles(input int n);
    @(negedge clk);
    start    <= 1'b0;
    codeword <= CW_W'({$urandom, $urandom});
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off the sender until every queued decode has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);
  endtask

  task automatic set_parity(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    parity_setting = value;
  endtask

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d decodes outstanding", $time, pending_decodes.size());
      $display("tb_hamming_sec_decoder_core failed");
      $finish;
    end
  end

  // Check each result strobe against the oldest queued decode
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_decodes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: data_bits=%h syndrome=%0d",
                 $time, data_bits, syndrome);
      end else begin
        oldest = pending_decodes.pop_front();
        results_checked++;
        if (data_bits !== oldest.data_bits) begin
          mismatches++;
          $display("%0t: data_bits expected %h actual %h", $time, oldest.data_bits, data_bits);
        end
        if (syndrome !== oldest.syndrome) begin
          mismatches++;
          $display("%0t: syndrome expected %0d actual %0d", $time, oldest.syndrome, syndrome);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [CFG_W-1:0] phase_parity [0:N_PHASES-1];
    int               idle_odds;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    start           = 1'b0;
    codeword        = '0;
    cycle_count     = 0;
    codewords_sent  = 0;
    results_checked = 0;
    mismatches      = 0;
    parity_setting  = PARITY_RESET;
    phase_parity    = '{3'd6, 3'd1, 3'd7, 3'd3, 3'd0, 3'd2, 3'd4, 3'd5, 3'd6};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].parity != parity_setting) set_parity(directed_rows[i].parity);
      send_codeword(directed_rows[i].cw, directed_rows[i].typed,
                    hsd_result_t'{data_bits: directed_rows[i].data,
                                  syndrome:  directed_rows[i].syn});
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 16));
    end

    // Random phases, one parity setting each; the last runs flat out
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_parity(phase_parity[ph]);
      idle_odds = (ph == N_PHASES - 1) ? 0 : ((ph % 2) ? 4 : 12);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_codeword(random_codeword(parity_setting), 1'b0, '0);
        if (ph == 4 && k == PHASE_ITEMS / 2) wait_drained();
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          idle_cycles($urandom_range(1, 16));
      end
    end

    // Drain, then allow for the pipeline depth
    wait_drained();
    repeat (4) @(posedge clk);
    $display("Decoded %0d codewords over all parity settings 0 to 7, clean and with",
             codewords_sent);
    $display("single, double and random errors; %0d results checked.", results_checked);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("tb_hamming_sec_decoder_core passed");
    end else begin
      $display("tb_hamming_sec_decoder_core failed");
    end
    $finish;
  end

endmodule

>>> hamming_sec_decoder_core.f
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_decode.sv
hw/rtl/hamming_sec_decoder_core.sv
tb/tb_hamming_sec_decoder_core.sv
